### src/assert_macros.svh
// Assertion macros used by the checker file.
// Include by bare file name; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/scs_pkg.sv
// Package for the sparse coordinate entry sorter.
// Operation and status codes, entry packing, sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scs_pkg;

   localparam int IDX_W   = 10;
   localparam int VAL_W   = 64;
   localparam int CNT_W   = 11;
   localparam int ENTRY_W = 2 * IDX_W + VAL_W;
   localparam int CSR_AW  = 1;

   localparam logic [CNT_W-1:0] COUNT_LIMIT = 11'h7FF;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_SORT   = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_QUERY  = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_COLS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIN,
      ST_LOAD,
      ST_KEY,
      ST_CMP,
      ST_PLACE
   } state_type;

   typedef struct packed {
      logic rd;
      logic bump;
      logic set_diag;
   } row_op_type;

endpackage

`default_nettype wire

### src/scs_entry_ram.sv
// Entry list memory: one write port, one read port with registered read data.
// Uses nothing from the package.
`timescale 1ns / 1ps
`default_nettype none

module scs_entry_ram #(
   parameter int WIDTH = 84,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### src/scs_row_table.sv
// Per-row entry counts and diagonal values, with a clearing pass after reset.
// Depends on scs_pkg for widths, the count limit and the row operation struct.
`timescale 1ns / 1ps
`default_nettype none

module scs_row_table
   import scs_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire row_op_type               op,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [VAL_W-1:0]         diag_value,
   output logic      [CNT_W-1:0]         rd_count,
   output logic      [VAL_W-1:0]         rd_diag,
   output logic                          busy
);

   localparam int AW = $clog2(DEPTH);

   logic [CNT_W-1:0] cnt_mem  [DEPTH];
   logic [VAL_W-1:0] diag_mem [DEPTH];

   logic          busy_ff, busy_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          bump_ff, bump_in;
   logic [AW-1:0] addr_ff;
   logic [CNT_W-1:0] cnt_next;

   assign busy     = busy_ff;
   assign bump_in  = op.bump & ~busy_ff;
   assign cnt_next = (rd_count == COUNT_LIMIT) ? rd_count : rd_count + 1'b1;

   always_comb begin
      busy_in = busy_ff;
      clr_in  = clr_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
         bump_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
         bump_ff <= bump_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr;
      if (busy_ff) begin
         cnt_mem[clr_ff]  <= '0;
         diag_mem[clr_ff] <= '0;
      end else begin
         if (op.rd || op.bump) begin
            rd_count <= cnt_mem[addr];
            rd_diag  <= diag_mem[addr];
         end
         if (op.set_diag) begin
            diag_mem[addr] <= diag_value;
         end
         if (bump_ff) begin
            cnt_mem[addr_ff] <= cnt_next;
         end
      end
   end

endmodule

`default_nettype wire

### src/sparse_coordinate_entry_sorter_core.sv
// Sparse coordinate entry sorter. Keeps a list of (row, column, value) entries with a
// count and a diagonal value per row; insert, stable sort (row- or column-major), read,
// row query and clear. One item is taken at a time: for insert, read, query, clear and
// unknown codes the state register moves to the finish state and the response is then
// registered, and the next item is taken once that result has been transferred. Sort is
// an insertion sort over the entry memory with a single key comparator. After reset the
// row table runs a clearing pass over all MAX_ROWS rows before the first item is taken;
// configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module sparse_coordinate_entry_sorter_core
   import scs_pkg::*;
#(
   parameter int MAX_ROWS    = 1024,
   parameter int MAX_COLS    = 1024,
   parameter int MAX_ENTRIES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_addr,
   input  wire logic [CNT_W-1:0]  csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [2:0]        req_operation,
   input  wire logic [IDX_W-1:0]  req_row_index,
   input  wire logic [IDX_W-1:0]  req_col_index,
   input  wire logic [VAL_W-1:0]  req_entry_value,
   input  wire logic [IDX_W-1:0]  req_entry_position,
   input  wire logic              req_column_major,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [IDX_W-1:0]       rsp_out_row,
   output logic [IDX_W-1:0]       rsp_out_col,
   output logic [VAL_W-1:0]       rsp_out_value,
   output logic [CNT_W-1:0]       rsp_row_entry_count,
   output logic [VAL_W-1:0]       rsp_row_diagonal,
   output logic [CNT_W-1:0]       rsp_stored_count
);

   localparam int EA = $clog2(MAX_ENTRIES);
   localparam int TW = EA + 1;
   localparam int RA = $clog2(MAX_ROWS);

   state_type        state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic [1:0]       status_ff, status_in;
   logic [TW-1:0]    total_ff, total_in;
   logic             colmaj_ff, colmaj_in;
   logic [TW-1:0]    i_ff, i_in;
   logic [EA-1:0]    j_ff, j_in;
   logic [ENTRY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] rows_ff, cols_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in, rsp_diag_ff, rsp_diag_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in, rsp_total_ff, rsp_total_in;

   logic               ram_we;
   logic [EA-1:0]      ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   row_op_type       row_op;
   logic [CNT_W-1:0] row_count;
   logic [VAL_W-1:0] row_diag;
   logic             row_busy;

   logic             accept, row_ok, col_ok, greater;
   logic [2*IDX_W-1:0] probe_key, held_key;

   scs_entry_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   scs_row_table #(.DEPTH(MAX_ROWS)) u_row_table (
      .clock      (clock),
      .reset      (reset),
      .op         (row_op),
      .addr       (RA'(req_row_index)),
      .diag_value (req_entry_value),
      .rd_count   (row_count),
      .rd_diag    (row_diag),
      .busy       (row_busy)
   );

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff && !row_busy;
   assign accept    = req_valid && req_ready;
   assign row_ok    = (32'(req_row_index) < 32'(rows_ff)) && (32'(req_row_index) < MAX_ROWS);
   assign col_ok    = (32'(req_col_index) < 32'(cols_ff)) && (32'(req_col_index) < MAX_COLS);

   // Key order: [83:74] row, [73:64] column.
   assign probe_key = colmaj_ff ? {ram_rdata[73:64], ram_rdata[83:74]} : ram_rdata[83:64];
   assign held_key  = colmaj_ff ? {key_ff[73:64], key_ff[83:74]} : key_ff[83:64];
   assign greater   = probe_key > held_key;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_out_row         = rsp_row_ff;
   assign rsp_out_col         = rsp_col_ff;
   assign rsp_out_value       = rsp_value_ff;
   assign rsp_row_entry_count = rsp_count_ff;
   assign rsp_row_diagonal    = rsp_diag_ff;
   assign rsp_stored_count    = rsp_total_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      status_in = status_ff;
      total_in  = total_ff;
      colmaj_in = colmaj_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      key_in    = key_ff;
      ram_we    = 1'b0;
      ram_waddr = EA'(total_ff);
      ram_wdata = {req_row_index, req_col_index, req_entry_value};
      ram_raddr = EA'(req_entry_position);
      row_op    = '0;

      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_diag_in   = rsp_diag_ff;
      rsp_total_in  = rsp_total_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_operation;
               status_in = STATUS_OK;
               state_in  = ST_FIN;
               unique case (req_operation)
                  OP_INSERT: begin
                     if (!row_ok || !col_ok) begin
                        status_in = STATUS_RANGE;
                     end else if (32'(total_ff) >= MAX_ENTRIES) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ram_we          = 1'b1;
                        total_in        = total_ff + 1'b1;
                        row_op.bump     = 1'b1;
                        row_op.set_diag = (req_row_index == req_col_index);
                     end
                  end
                  OP_SORT: begin
                     colmaj_in = req_column_major;
                     i_in      = TW'(1);
                     state_in  = ST_LOAD;
                  end
                  OP_READ: begin
                     if (32'(req_entry_position) >= 32'(total_ff)) begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  OP_QUERY: begin
                     if (!row_ok) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        row_op.rd = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     total_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            ram_raddr = EA'(i_ff);
            state_in  = (i_ff >= total_ff) ? ST_FIN : ST_KEY;
         end
         ST_KEY: begin
            key_in    = ram_rdata;
            j_in      = EA'(i_ff);
            ram_raddr = EA'(i_ff) - 1'b1;
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            if (greater) begin
               ram_we    = 1'b1;
               ram_waddr = j_ff;
               ram_wdata = ram_rdata;
               ram_raddr = j_ff - EA'(2);
               j_in      = j_ff - 1'b1;
               if (j_ff == EA'(1)) begin
                  state_in = ST_PLACE;
               end
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_wdata = key_ff;
            i_in      = i_ff + 1'b1;
            state_in  = ST_LOAD;
         end
         ST_FIN: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_row_in    = '0;
            rsp_col_in    = '0;
            rsp_value_in  = '0;
            rsp_count_in  = '0;
            rsp_diag_in   = '0;
            rsp_total_in  = CNT_W'(total_ff);
            if (status_ff == STATUS_OK && op_ff == OP_READ) begin
               rsp_row_in   = ram_rdata[83:74];
               rsp_col_in   = ram_rdata[73:64];
               rsp_value_in = ram_rdata[63:0];
            end
            if (status_ff == STATUS_OK && op_ff == OP_QUERY) begin
               rsp_count_in = row_count;
               rsp_diag_in  = row_diag;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= CNT_W'(1024);
         cols_ff      <= CNT_W'(1024);
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_addr == CSR_ROWS) begin
            rows_ff <= csr_wdata;
         end
         if (csr_we && csr_addr == CSR_COLS) begin
            cols_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      colmaj_ff     <= colmaj_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_diag_ff   <= rsp_diag_in;
      rsp_total_ff  <= rsp_total_in;
   end

endmodule

`default_nettype wire

### src/scs_checker.sv
// Port-level checks for the sparse coordinate entry sorter, bound to the top level.
// Depends on scs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module scs_checker
   import scs_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [1:0]        rsp_status,
   input wire logic [IDX_W-1:0]  rsp_out_row,
   input wire logic [VAL_W-1:0]  rsp_out_value,
   input wire logic [CNT_W-1:0]  rsp_row_entry_count,
   input wire logic [VAL_W-1:0]  rsp_row_diagonal,
   input wire logic [CNT_W-1:0]  rsp_stored_count
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_stored_count) && $stable(rsp_out_value))
   `ASSERT_NOW(a_one_in_flight, clock, reset, req_valid && req_ready, !rsp_valid)
   `ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status == STATUS_OK || rsp_status == STATUS_RANGE || rsp_status == STATUS_FULL)
   `ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_out_row == '0 && rsp_out_value == '0 && rsp_row_entry_count == '0 && rsp_row_diagonal == '0)

endmodule

bind sparse_coordinate_entry_sorter_core scs_checker u_scs_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_status          (rsp_status),
   .rsp_out_row         (rsp_out_row),
   .rsp_out_value       (rsp_out_value),
   .rsp_row_entry_count (rsp_row_entry_count),
   .rsp_row_diagonal    (rsp_row_diagonal),
   .rsp_stored_count    (rsp_stored_count)
);

`default_nettype wire

### tb/sparse_coordinate_entry_sorter_core_test.sv
// Testbench for sparse_coordinate_entry_sorter_core: directed and random operation streams,
// checked against a behavioural coordinate-store predictor held in this file.
// Depends on scs_pkg and the core RTL only.
`timescale 1ns / 1ps

module sparse_coordinate_entry_sorter_core_test;
   import scs_pkg::*;

   localparam int STORE_DEPTH  = 1024;
   localparam int WATCHDOG_MAX = 2_000_000;
   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      logic [1:0]       status;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [VAL_W-1:0] value;
      logic [CNT_W-1:0] count;
      logic [VAL_W-1:0] diag;
      logic [CNT_W-1:0] stored;
   } outcome_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = CSR_ROWS;
   logic [CNT_W-1:0]  csr_wdata = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [2:0]        req_operation = OP_CLEAR;
   logic [IDX_W-1:0]  req_row_index = '0;
   logic [IDX_W-1:0]  req_col_index = '0;
   logic [VAL_W-1:0]  req_entry_value = '0;
   logic [IDX_W-1:0]  req_entry_position = '0;
   logic              req_column_major = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_status;
   logic [IDX_W-1:0]  rsp_out_row;
   logic [IDX_W-1:0]  rsp_out_col;
   logic [VAL_W-1:0]  rsp_out_value;
   logic [CNT_W-1:0]  rsp_row_entry_count;
   logic [VAL_W-1:0]  rsp_row_diagonal;
   logic [CNT_W-1:0]  rsp_stored_count;

   sparse_coordinate_entry_sorter_core dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [IDX_W-1:0] coo_row [STORE_DEPTH];
   logic [IDX_W-1:0] coo_col [STORE_DEPTH];
   logic [VAL_W-1:0] coo_val [STORE_DEPTH];
   logic [CNT_W-1:0] row_tally [STORE_DEPTH];
   logic [VAL_W-1:0] row_diag [STORE_DEPTH];
   int               coo_total;
   logic [CNT_W-1:0] rows_cfg, cols_cfg;

   outcome_type pending_outcomes[$];
   int       mismatches, items_sent, outcomes_seen, csr_writes, idle_cycles;
   bit       no_gaps, no_stalls;
   int       stall_hold;

   function automatic int row_limit();
      return (rows_cfg < STORE_DEPTH) ? int'(rows_cfg) : STORE_DEPTH;
   endfunction

   function automatic int col_limit();
      return (cols_cfg < STORE_DEPTH) ? int'(cols_cfg) : STORE_DEPTH;
   endfunction

   function automatic void sort_store(bit colmaj);
      logic [IDX_W-1:0] r, c;
      logic [VAL_W-1:0] v;
      logic [2*IDX_W-1:0] k;
      int j;
      for (int i = 1; i < coo_total; i++) begin
         r = coo_row[i];
         c = coo_col[i];
         v = coo_val[i];
         k = colmaj ? {c, r} : {r, c};
         j = i;
         while (j > 0 && (colmaj ? {coo_col[j-1], coo_row[j-1]}
                                 : {coo_row[j-1], coo_col[j-1]}) > k) begin
            coo_row[j] = coo_row[j-1];
            coo_col[j] = coo_col[j-1];
            coo_val[j] = coo_val[j-1];
            j--;
         end
         coo_row[j] = r;
         coo_col[j] = c;
         coo_val[j] = v;
      end
   endfunction

   function automatic outcome_type apply_operation(logic [2:0] op, logic [IDX_W-1:0] row,
                                                logic [IDX_W-1:0] col, logic [VAL_W-1:0] val,
                                                logic [IDX_W-1:0] pos, logic colmaj);
      outcome_type o;
      o = '{STATUS_OK, '0, '0, '0, '0, '0, '0};
      case (op)
         OP_INSERT: begin
            if (row >= row_limit() || col >= col_limit()) o.status = STATUS_RANGE;
            else if (coo_total >= STORE_DEPTH) o.status = STATUS_FULL;
            else begin
               coo_row[coo_total] = row;
               coo_col[coo_total] = col;
               coo_val[coo_total] = val;
               coo_total++;
               if (row_tally[row] < COUNT_LIMIT) row_tally[row]++;
               if (row == col) row_diag[row] = val;
            end
         end
         OP_SORT: sort_store(colmaj);
         OP_READ: begin
            if (pos >= coo_total) o.status = STATUS_RANGE;
            else begin
               o.row = coo_row[pos];
               o.col = coo_col[pos];
               o.value = coo_val[pos];
            end
         end
         OP_QUERY: begin
            if (row >= row_limit()) o.status = STATUS_RANGE;
            else begin
               o.count = row_tally[row];
               o.diag = row_diag[row];
            end
         end
         OP_CLEAR: coo_total = 0;
         default: ;
      endcase
      o.stored = CNT_W'(coo_total);
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   task automatic send_item(logic [2:0] op, logic [IDX_W-1:0] row = '0,
                            logic [IDX_W-1:0] col = '0, logic [VAL_W-1:0] val = '0,
                            logic [IDX_W-1:0] pos = '0, logic colmaj = 1'b0);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation <= op;
      req_row_index <= row;
      req_col_index <= col;
      req_entry_value <= val;
      req_entry_position <= pos;
      req_column_major <= colmaj;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_outcomes.push_back(apply_operation(op, row, col, val, pos, colmaj));
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_AW-1:0] addr, logic [CNT_W-1:0] data);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_ROWS) rows_cfg = data;
      else cols_cfg = data;
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic set_bounds(logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols);
      drain();
      write_csr(CSR_ROWS, rows);
      write_csr(CSR_COLS, cols);
   endtask

   task automatic insert_in_bounds(bit narrow);
      int rl, cl;
      logic [IDX_W-1:0] r, c;
      rl = row_limit();
      cl = col_limit();
      if (narrow) begin
         if (rl > 4) rl = 4;
         if (cl > 4) cl = 4;
      end
      r = IDX_W'($urandom_range(0, rl - 1));
      c = IDX_W'($urandom_range(0, cl - 1));
      if ($urandom_range(0, 5) == 0 && r < col_limit()) c = r;
      send_item(OP_INSERT, r, c, {$urandom, $urandom});
   endtask

   // response side: random back-pressure
   always @(posedge clock) begin
      int r;
      if (no_stalls) rsp_ready <= 1'b1;
      else if (stall_hold > 0) begin
         stall_hold--;
         rsp_ready <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) rsp_ready <= 1'b1;
         else begin
            rsp_ready <= 1'b0;
            stall_hold = (r < 93) ? $urandom_range(0, 2) : $urandom_range(5, 30);
         end
      end
   end

   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         outcomes_seen++;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
         end else begin
            e = pending_outcomes.pop_front();
            if (rsp_status !== e.status || rsp_out_row !== e.row || rsp_out_col !== e.col ||
                rsp_out_value !== e.value || rsp_row_entry_count !== e.count ||
                rsp_row_diagonal !== e.diag || rsp_stored_count !== e.stored) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t: exp st=%0d r=%0d c=%0d v=%h n=%0d d=%h s=%0d",
                           $realtime, e.status, e.row, e.col, e.value, e.count, e.diag,
                           e.stored);
                  $display("                 got st=%0d r=%0d c=%0d v=%h n=%0d d=%h s=%0d",
                           rsp_status, rsp_out_row, rsp_out_col, rsp_out_value,
                           rsp_row_entry_count, rsp_row_diagonal, rsp_stored_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic test_empty_store();
      send_item(OP_READ, '0, '0, '0, '0);
      send_item(OP_READ, '0, '0, '0, '1);
      send_item(OP_QUERY, '0);
      send_item(OP_QUERY, '1);
      send_item(OP_SORT, '0, '0, '0, '0, 1'b1);
      send_item(OP_CLEAR);
      send_item(OP_SPARE_5, '1, '1, '1, '1, 1'b1);
      send_item(OP_SPARE_6);
      send_item(OP_SPARE_7, '1, '0, '1, '0, 1'b0);
   endtask

   task automatic test_basic_ops();
      send_item(OP_INSERT, 10'd1023, 10'd1023, '1);
      send_item(OP_INSERT, 10'd0, 10'd0, '0);
      send_item(OP_INSERT, 10'd5, 10'd2, 64'h0123_4567_89AB_CDEF);
      send_item(OP_INSERT, 10'd2, 10'd5, 64'hFEDC_BA98_7654_3210);
      send_item(OP_INSERT, 10'd5, 10'd2, 64'hAAAA_5555_AAAA_5555);
      send_item(OP_INSERT, 10'd5, 10'd5, 64'h8000_0000_0000_0001);
      send_item(OP_SORT, '0, '0, '0, '0, 1'b0);
      for (int i = 0; i < 6; i++) send_item(OP_READ, '0, '0, '0, IDX_W'(i));
      send_item(OP_SORT, '0, '0, '0, '0, 1'b1);
      for (int i = 0; i < 7; i++) send_item(OP_READ, '0, '0, '0, IDX_W'(i));
      send_item(OP_QUERY, 10'd5);
      send_item(OP_QUERY, 10'd1023);
      send_item(OP_CLEAR);
      send_item(OP_READ, '0, '0, '0, '0);
      send_item(OP_QUERY, 10'd5);
   endtask

   task automatic test_bounds();
      set_bounds(11'd4, 11'd8);
      send_item(OP_INSERT, 10'd4, 10'd0, 64'h1);
      send_item(OP_INSERT, 10'd3, 10'd8, 64'h2);
      send_item(OP_INSERT, 10'd1023, 10'd1023, 64'h3);
      send_item(OP_INSERT, 10'd3, 10'd7, 64'h4);
      send_item(OP_QUERY, 10'd4);
      send_item(OP_QUERY, 10'd3);
      set_bounds(11'd2047, 11'd2047);
      send_item(OP_INSERT, 10'd1023, 10'd1023, 64'h5);
      send_item(OP_QUERY, 10'd1023);
      set_bounds(11'd1, 11'd1);
      send_item(OP_INSERT, 10'd0, 10'd0, 64'h6);
      send_item(OP_INSERT, 10'd1, 10'd0, 64'h7);
      send_item(OP_QUERY, 10'd1);
      send_item(OP_CLEAR);
      set_bounds(11'd1024, 11'd1024);
   endtask

   task automatic test_full_store();
      no_gaps = 1'b1;
      send_item(OP_CLEAR);
      for (int i = 0; i < STORE_DEPTH; i++) insert_in_bounds(i % 2 == 0);
      send_item(OP_INSERT, 10'd1, 10'd2, 64'h9);
      send_item(OP_INSERT, 10'd1, 10'd1, 64'h9);
      drain();
      write_csr(CSR_ROWS, 11'd16);
      send_item(OP_INSERT, 10'd16, 10'd1, 64'hA);
      send_item(OP_SORT, '0, '0, '0, '0, 1'b1);
      for (int i = 0; i < 12; i++)
         send_item(OP_READ, '0, '0, '0, IDX_W'($urandom_range(0, 1023)));
      send_item(OP_READ, '0, '0, '0, 10'd1023);
      send_item(OP_CLEAR);
      no_gaps = 1'b0;
      set_bounds(11'd1024, 11'd1024);
   endtask

   task automatic test_row_count();
      no_gaps = 1'b1;
      for (int i = 0; i < 6; i++)
         send_item(OP_INSERT, 10'd9, IDX_W'($urandom_range(0, 1023)), {$urandom, $urandom});
      send_item(OP_INSERT, 10'd9, 10'd9, 64'h5A5A);
      send_item(OP_QUERY, 10'd9);
      send_item(OP_CLEAR);
      send_item(OP_QUERY, 10'd9);
      no_gaps = 1'b0;
   endtask

   task automatic test_random_traffic(int target);
      int start, k, r;
      bit narrow;
      start = items_sent;
      while (items_sent - start < target) begin
         if ($urandom_range(0, 9) == 0) begin
            // hold off until the response queue is empty, then retune the bounds
            r = $urandom_range(0, 4);
            case (r)
               0: set_bounds(11'd1024, 11'd1024);
               1: set_bounds(CNT_W'($urandom_range(1, 16)), CNT_W'($urandom_range(1, 16)));
               2: set_bounds(CNT_W'($urandom_range(1, 2047)),
                             CNT_W'($urandom_range(1, 2047)));
               3: set_bounds(11'd2047, CNT_W'($urandom_range(1, 1024)));
               default: set_bounds(CNT_W'($urandom_range(1, 1024)), 11'd1);
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            no_stalls = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 99) < 85) begin
            narrow = 1'($urandom_range(0, 1));
            send_item(OP_CLEAR);
            k = $urandom_range(1, 24);
            for (int i = 0; i < k; i++) begin
               if ($urandom_range(0, 15) == 0)
                  send_item(OP_INSERT, IDX_W'($urandom), IDX_W'($urandom),
                            {$urandom, $urandom});
               else insert_in_bounds(narrow);
            end
            send_item(OP_SORT, '0, '0, '0, '0, 1'($urandom_range(0, 1)));
            for (int i = 0; i <= coo_total; i++)
               if ($urandom_range(0, 3) != 0) send_item(OP_READ, '0, '0, '0, IDX_W'(i));
            for (int i = 0; i < 3; i++)
               send_item(OP_QUERY, IDX_W'($urandom_range(0, row_limit() > 4 && !narrow ?
                                                         row_limit() - 1 : 4)));
         end else begin
            k = $urandom_range(1, 10);
            for (int i = 0; i < k; i++)
               send_item(3'($urandom_range(0, 7)), IDX_W'($urandom), IDX_W'($urandom),
                         {$urandom, $urandom}, IDX_W'($urandom), 1'($urandom_range(0, 1)));
         end
      end
      no_gaps = 1'b0;
      no_stalls = 1'b0;
   endtask

   initial begin
      rows_cfg = 11'd1024;
      cols_cfg = 11'd1024;
      coo_total = 0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         row_tally[i] = '0;
         row_diag[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_store();
      test_basic_ops();
      test_bounds();
      test_full_store();
      test_row_count();
      test_random_traffic(100);
      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d operations, %0d responses checked, %0d register writes",
               items_sent, outcomes_seen, csr_writes);
      $display("includes full store, row counts, bound changes and both sort orders");
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
